// File: src/trie_pkg.sv
// Shared constants, state type and controller/datapath handshake structs for the trie.
`timescale 1ns / 1ps

package trie_pkg;

    localparam int NODES_DEF    = 256;
    localparam int ALPHABET_DEF = 26;
    localparam int LETTER_W     = 5;
    localparam int NUSED_W      = 9;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK,
        S_MARK,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic clear;
        logic accept;
        logic walk;
        logic mark;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic clear_done;
        logic item_empty;
        logic item_last;
        logic out_free;
    } t_status;

endpackage

// File: src/trie_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module trie_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic                     i_we,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/trie_ctrl.sv
// Controller state machine: clearing pass, letter walk, end-mark access and result beat.
`timescale 1ns / 1ps

module trie_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  trie_pkg::t_status i_status,
    output trie_pkg::t_cmd   o_cmd,
    output logic             o_in_stall
);

    trie_pkg::t_state r_state;
    trie_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= trie_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            trie_pkg::S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_status.clear_done) begin
                    n_state = trie_pkg::S_IDLE;
                end
            end
            trie_pkg::S_IDLE: begin
                o_in_stall   = 1'b0;
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = trie_pkg::S_WALK;
                end
            end
            trie_pkg::S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_status.item_empty || i_status.item_last) begin
                    n_state = trie_pkg::S_MARK;
                end else begin
                    n_state = trie_pkg::S_IDLE;
                end
            end
            trie_pkg::S_MARK: begin
                o_cmd.mark = 1'b1;
                n_state    = trie_pkg::S_EMIT;
            end
            trie_pkg::S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = trie_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = trie_pkg::S_CLEAR;
            end
        endcase
    end

endmodule

// File: src/trie_dp.sv
// Datapath: node store, end marks, cursor, free counter and the result register.
`timescale 1ns / 1ps

module trie_dp #(
    parameter int NODES    = trie_pkg::NODES_DEF,
    parameter int ALPHABET = trie_pkg::ALPHABET_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  trie_pkg::t_cmd                i_cmd,
    output trie_pkg::t_status             o_flags,
    input  logic                          i_func,
    input  logic [trie_pkg::LETTER_W-1:0] i_letter,
    input  logic                          i_last_letter,
    input  logic                          i_empty_key,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_found,
    output logic                          o_status,
    output logic [trie_pkg::NUSED_W-1:0]  o_nodes_used
);

    localparam int DEPTH = NODES * ALPHABET;
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = $clog2(NODES);
    localparam int FW    = $clog2(NODES + 1);

    // item
    logic                          r_func;
    logic [trie_pkg::LETTER_W-1:0] r_letter;
    logic                          r_last;
    logic                          r_empty;
    logic [AW-1:0]                 r_addr;

    // key state
    logic [NW-1:0] r_cursor, n_cursor;
    logic          r_ab, n_ab;
    logic          r_full, n_full;
    logic [FW-1:0] r_next_free, n_next_free;
    logic [AW-1:0] r_clr;

    // result
    logic                         r_out_valid;
    logic                         r_found;
    logic                         r_stat;
    logic [trie_pkg::NUSED_W-1:0] r_nused;

    logic [AW-1:0] walk_addr;
    logic [AW-1:0] c_addr;
    logic          c_we;
    logic [NW-1:0] c_wdata;
    logic [NW-1:0] c_rdata;
    logic          alloc;
    logic          letter_bad;
    logic          clr_end;
    logic [NW-1:0] e_addr;
    logic          e_we;
    logic          e_re;
    logic          e_rdata;
    logic          mark_wr;
    logic          out_free;

    assign walk_addr  = AW'(32'(r_cursor) * 32'(ALPHABET) + 32'(i_letter));
    assign letter_bad = 32'(r_letter) >= ALPHABET;
    assign clr_end    = 32'(r_clr) < NODES;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign mark_wr    = i_cmd.mark && (r_func == trie_pkg::FUNC_INSERT) && !r_ab;

    always_comb begin
        n_cursor    = r_cursor;
        n_ab        = r_ab;
        n_full      = r_full;
        n_next_free = r_next_free;
        alloc       = 1'b0;
        if (i_cmd.walk) begin
            if (r_empty) begin
                n_cursor = '0;
                n_ab     = 1'b0;
                n_full   = 1'b0;
            end else if (!r_ab) begin
                priority if (letter_bad) begin
                    n_ab = 1'b1;
                end else if (c_rdata != '0) begin
                    n_cursor = c_rdata;
                end else if (r_func == trie_pkg::FUNC_SEARCH) begin
                    n_ab = 1'b1;
                end else if (r_next_free == FW'(NODES)) begin
                    n_ab   = 1'b1;
                    n_full = 1'b1;
                end else begin
                    alloc       = 1'b1;
                    n_cursor    = NW'(r_next_free);
                    n_next_free = r_next_free + FW'(1);
                end
            end
        end
        if (i_cmd.emit) begin
            n_cursor = '0;
            n_ab     = 1'b0;
            n_full   = 1'b0;
        end
    end

    assign c_addr  = i_cmd.clear ? r_clr : (i_cmd.accept ? walk_addr : r_addr);
    assign c_we    = i_cmd.clear || alloc;
    assign c_wdata = i_cmd.clear ? '0 : NW'(r_next_free);

    assign e_addr = i_cmd.clear ? r_clr[NW-1:0] : r_cursor;
    assign e_we   = (i_cmd.clear && clr_end) || mark_wr;
    assign e_re   = i_cmd.mark && !mark_wr;

    trie_ram #(
        .WIDTH (NW),
        .DEPTH (DEPTH)
    ) u_child (
        .i_clk   (i_clk),
        .i_addr  (c_addr),
        .i_we    (c_we),
        .i_wdata (c_wdata),
        .i_re    (i_cmd.accept),
        .o_rdata (c_rdata)
    );

    trie_ram #(
        .WIDTH (1),
        .DEPTH (NODES)
    ) u_marks (
        .i_clk   (i_clk),
        .i_addr  (e_addr),
        .i_we    (e_we),
        .i_wdata (!i_cmd.clear),
        .i_re    (e_re),
        .o_rdata (e_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor    <= '0;
            r_ab        <= 1'b0;
            r_full      <= 1'b0;
            r_next_free <= FW'(1);
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cursor    <= n_cursor;
            r_ab        <= n_ab;
            r_full      <= n_full;
            r_next_free <= n_next_free;
            if (i_cmd.clear) begin
                r_clr <= r_clr + AW'(1);
            end
            r_out_valid <= i_cmd.emit || (r_out_valid && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_func   <= i_func;
            r_letter <= i_letter;
            r_last   <= i_last_letter;
            r_empty  <= i_empty_key;
            r_addr   <= walk_addr;
        end
        if (i_cmd.emit) begin
            r_found <= (r_func == trie_pkg::FUNC_SEARCH) && !r_ab && e_rdata;
            r_stat  <= (r_func == trie_pkg::FUNC_INSERT) && r_full;
            r_nused <= trie_pkg::NUSED_W'(r_next_free);
        end
    end

    assign o_flags.clear_done = r_clr == AW'(DEPTH - 1);
    assign o_flags.item_empty = r_empty;
    assign o_flags.item_last  = r_last;
    assign o_flags.out_free   = out_free;

    assign o_out_valid  = r_out_valid;
    assign o_found      = r_found;
    assign o_status     = r_stat;
    assign o_nodes_used = r_nused;

endmodule

// File: src/trie_insert_search.sv
// A letter takes two steps (child read, then walk/allocate); a final or empty-key beat gives
// its result through walk, end-mark access and the result register. A new letter is taken
// only after the walk/allocate step of the last one, set by the single port of the child-table
// RAM; final letters also wait for the end-mark access and result beat. The result register
// frees the input side while a beat waits. Reset: synchronous, active low; it starts a
// clearing pass over the child table and end marks, with input stalled throughout.
`timescale 1ns / 1ps

module trie_insert_search #(
    parameter int NODES    = trie_pkg::NODES_DEF,
    parameter int ALPHABET = trie_pkg::ALPHABET_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_func,
    input  logic [trie_pkg::LETTER_W-1:0] i_letter,
    input  logic                          i_last_letter,
    input  logic                          i_empty_key,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_found,
    output logic                          o_status,
    output logic [trie_pkg::NUSED_W-1:0]  o_nodes_used
);

    trie_pkg::t_cmd    cmd;
    trie_pkg::t_status stat;

    trie_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    trie_dp #(
        .NODES    (NODES),
        .ALPHABET (ALPHABET)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_flags       (stat),
        .i_func        (i_func),
        .i_letter      (i_letter),
        .i_last_letter (i_last_letter),
        .i_empty_key   (i_empty_key),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_found       (o_found),
        .o_status      (o_status),
        .o_nodes_used  (o_nodes_used)
    );

endmodule

// File: bench/testbench.sv
// Self-checking testbench for the trie insert/search block.
`timescale 1ns / 1ps

module testbench;

    localparam int NODES      = trie_pkg::NODES_DEF;
    localparam int ALPHABET   = trie_pkg::ALPHABET_DEF;
    localparam int QUIET_MAX  = 20000;
    localparam int TAIL_WAIT  = 12;
    localparam int IDLE_PCT   = 32;

    typedef logic [trie_pkg::LETTER_W-1:0] t_letter;
    typedef logic [trie_pkg::NUSED_W-1:0]  t_nused;

    typedef struct packed {
        logic   found;
        logic   status;
        t_nused nodes_used;
    } t_key_outcome;

    logic    i_clk         = 1'b0;
    logic    i_rst_n       = 1'b0;
    logic    i_in_valid    = 1'b0;
    logic    i_func        = trie_pkg::FUNC_INSERT;
    t_letter i_letter      = '0;
    logic    i_last_letter = 1'b0;
    logic    i_empty_key   = 1'b0;
    logic    i_out_stall   = 1'b0;
    logic    o_in_stall;
    logic    o_out_valid;
    logic    o_found;
    logic    o_status;
    t_nused  o_nodes_used;

    // Shadow trie
    logic [7:0] child_of [0:NODES*ALPHABET-1];
    bit         end_mark [0:NODES-1];
    t_nused     free_cnt;
    logic [7:0] cur_node;
    bit         abandoned;
    bit         full_seen;

    t_key_outcome outcomes_q[$];
    int           err_cnt     = 0;
    int           beat_cnt    = 0;
    int           quiet_cycles = 0;
    int           hold_left   = 0;
    bit           calm        = 1'b0;

    trie_insert_search u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_func        (i_func),
        .i_letter      (i_letter),
        .i_last_letter (i_last_letter),
        .i_empty_key   (i_empty_key),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_found       (o_found),
        .o_status      (o_status),
        .o_nodes_used  (o_nodes_used)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic void trie_clear();
        foreach (child_of[i]) child_of[i] = '0;
        foreach (end_mark[i]) end_mark[i] = 1'b0;
        free_cnt  = t_nused'(1);
        cur_node  = '0;
        abandoned = 1'b0;
        full_seen = 1'b0;
    endfunction

    function automatic void trie_follow(input logic func, input t_letter letter);
        int unsigned slot;
        logic [7:0]  child;
        if (abandoned) return;
        if (letter >= ALPHABET) begin
            abandoned = 1'b1;
            return;
        end
        slot  = cur_node * ALPHABET + letter;
        child = child_of[slot];
        if (child == '0) begin
            if (func == trie_pkg::FUNC_SEARCH) begin
                abandoned = 1'b1;
                return;
            end
            if (free_cnt >= NODES) begin
                abandoned = 1'b1;
                full_seen = 1'b1;
                return;
            end
            child = free_cnt[7:0];
            free_cnt++;
            child_of[slot] = child;
        end
        cur_node = child;
    endfunction

    function automatic void trie_close(input logic func);
        t_key_outcome res;
        res = '0;
        if (func == trie_pkg::FUNC_SEARCH) begin
            if (!abandoned) res.found = end_mark[cur_node];
        end else begin
            if (!abandoned) end_mark[cur_node] = 1'b1;
            res.status = full_seen;
        end
        res.nodes_used = free_cnt;
        outcomes_q.push_back(res);
        cur_node  = '0;
        abandoned = 1'b0;
        full_seen = 1'b0;
    endfunction

    function automatic void trie_beat(input logic func, input t_letter letter,
                                      input logic last, input logic empty);
        if (empty) begin
            cur_node  = '0;
            abandoned = 1'b0;
            full_seen = 1'b0;
            trie_close(func);
        end else begin
            trie_follow(func, letter);
            if (last) trie_close(func);
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch: %s got %0d expected %0d", $time, what, got, want);
        err_cnt++;
    endtask

    // Result side: compare every beat against the oldest outcome.
    always @(posedge i_clk) begin
        t_key_outcome want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (outcomes_q.size() == 0) begin
                report_mismatch("result with none pending, nodes_used", o_nodes_used, 0);
            end else begin
                want = outcomes_q.pop_front();
                if (o_found !== want.found)
                    report_mismatch("found", o_found, want.found);
                if (o_status !== want.status)
                    report_mismatch("status", o_status, want.status);
                if (o_nodes_used !== want.nodes_used)
                    report_mismatch("nodes_used", o_nodes_used, want.nodes_used);
            end
        end
    end

    // Result-side stall: random, off when calm, forced during a hold-off.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (calm) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_MAX) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Offers one beat and returns at the edge that accepts it.
    task automatic send_beat(input logic func, input t_letter letter,
                             input logic last, input logic empty);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(99) < IDLE_PCT) gap = $urandom_range(1, 4);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_func        <= func;
        i_letter      <= letter;
        i_last_letter <= last;
        i_empty_key   <= empty;
        do @(posedge i_clk); while (o_in_stall);
        trie_beat(func, letter, last, empty);
        beat_cnt++;
    endtask

    task automatic send_key(input logic func, input int len, input int hi, input bit mixed);
        logic    f;
        t_letter l;
        for (int k = 0; k < len; k++) begin
            f = mixed ? logic'($urandom_range(1)) : func;
            l = t_letter'($urandom_range(hi));
            send_beat(f, l, k == len - 1, 1'b0);
        end
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (outcomes_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_beat(trie_pkg::FUNC_SEARCH, 5'd31, 1'b0, 1'b1);   // empty key on a fresh store
        send_beat(trie_pkg::FUNC_INSERT, 5'd0,  1'b0, 1'b1);   // marks the root
        send_beat(trie_pkg::FUNC_SEARCH, 5'd0,  1'b1, 1'b1);
        send_beat(trie_pkg::FUNC_INSERT, 5'd0,  1'b1, 1'b0);
        send_beat(trie_pkg::FUNC_SEARCH, 5'd0,  1'b1, 1'b0);
        send_beat(trie_pkg::FUNC_SEARCH, 5'd25, 1'b1, 1'b0);   // missing child
        send_beat(trie_pkg::FUNC_INSERT, 5'd25, 1'b1, 1'b0);
        send_beat(trie_pkg::FUNC_INSERT, 5'd0,  1'b0, 1'b0);
        send_beat(trie_pkg::FUNC_INSERT, 5'd25, 1'b1, 1'b0);
        send_beat(trie_pkg::FUNC_SEARCH, 5'd0,  1'b0, 1'b0);
        send_beat(trie_pkg::FUNC_SEARCH, 5'd25, 1'b1, 1'b0);
        send_beat(trie_pkg::FUNC_SEARCH, 5'd1,  1'b0, 1'b0);   // abandoned, rest ignored
        send_beat(trie_pkg::FUNC_SEARCH, 5'd2,  1'b1, 1'b0);
        send_beat(trie_pkg::FUNC_INSERT, 5'd26, 1'b0, 1'b0);   // out of range letter
        send_beat(trie_pkg::FUNC_INSERT, 5'd0,  1'b1, 1'b0);
        send_beat(trie_pkg::FUNC_SEARCH, 5'd31, 1'b1, 1'b0);
        send_beat(trie_pkg::FUNC_SEARCH, 5'd0,  1'b0, 1'b0);   // mixed operations in one key
        send_beat(trie_pkg::FUNC_INSERT, 5'd1,  1'b1, 1'b0);
        send_beat(trie_pkg::FUNC_SEARCH, 5'd0,  1'b0, 1'b0);
        send_beat(trie_pkg::FUNC_SEARCH, 5'd1,  1'b1, 1'b0);
        send_beat(trie_pkg::FUNC_INSERT, 5'd2,  1'b0, 1'b0);
        send_beat(trie_pkg::FUNC_SEARCH, 5'd3,  1'b1, 1'b0);
        send_beat(trie_pkg::FUNC_INSERT, 5'd4,  1'b0, 1'b0);   // key dropped by an empty key
        send_beat(trie_pkg::FUNC_INSERT, 5'd5,  1'b0, 1'b0);
        send_beat(trie_pkg::FUNC_SEARCH, 5'd16, 1'b1, 1'b1);
        wait_drain();
    endtask

    task automatic test_random_keys(input int n_beats);
        int      stop_at;
        int      paused_at;
        int      r;
        int      len;
        int      bad_pos;
        logic    f;
        t_letter l;
        stop_at   = beat_cnt + n_beats;
        paused_at = beat_cnt + n_beats / 2;
        while (beat_cnt < stop_at) begin
            r = $urandom_range(99);
            f = logic'($urandom_range(1));
            if (beat_cnt >= paused_at && paused_at != 0) begin
                wait_drain();   // sender pauses until nothing is outstanding
                paused_at = 0;
            end
            if (r < 60) begin
                send_key(f, $urandom_range(1, 3), 3, 1'b0);
            end else if (r < 70) begin
                send_key(f, $urandom_range(1, 6), ALPHABET - 1, 1'b0);
            end else if (r < 78) begin
                send_key(f, $urandom_range(2, 4), 3, 1'b1);
            end else if (r < 85) begin
                l = t_letter'($urandom);
                send_beat(f, l, logic'($urandom_range(1)), 1'b1);
            end else if (r < 92) begin
                len = $urandom_range(1, 3);
                for (int k = 0; k < len; k++) begin
                    l = t_letter'($urandom_range(3));
                    send_beat(f, l, 1'b0, 1'b0);
                end
                l = t_letter'($urandom);
                send_beat(logic'($urandom_range(1)), l, logic'($urandom_range(1)), 1'b1);
            end else begin
                len     = $urandom_range(1, 4);
                bad_pos = $urandom_range(len - 1);
                for (int k = 0; k < len; k++) begin
                    l = t_letter'((k == bad_pos) ? $urandom_range(ALPHABET, 31)
                                                 : $urandom_range(3));
                    send_beat(f, l, k == len - 1, 1'b0);
                end
            end
        end
        wait_drain();
    endtask

    task automatic test_backpressure();
        hold_left = 400;
        repeat (40) send_key(logic'($urandom_range(1)), 1, 3, 1'b0);
        wait_drain();
    endtask

    task automatic test_calm();
        calm = 1'b1;
        repeat (30) send_key(logic'($urandom_range(1)), $urandom_range(1, 4), 3, 1'b0);
        calm = 1'b0;
        wait_drain();
    endtask

    task automatic test_fill_store();
        int tries;
        tries = 0;
        while (free_cnt < NODES && tries < 60) begin
            send_key(trie_pkg::FUNC_INSERT, 10, ALPHABET - 1, 1'b0);
            tries++;
        end
        repeat (6) send_key(trie_pkg::FUNC_INSERT, 3, ALPHABET - 1, 1'b0);
        repeat (6) send_key(logic'($urandom_range(1)), $urandom_range(1, 3), 3, 1'b0);
        wait_drain();
    endtask

    initial begin
        trie_clear();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_keys(380);
        test_backpressure();
        test_calm();
        test_fill_store();
        if (err_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
